>>> hdl/i2cbs_pkg.sv
// Package for the I2C master bit sequencer: phase codes, command kinds,
// register indexes and field widths. It depends on nothing else.
package i2cbs_pkg;

    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int TPU_W    = 16;
    localparam int TMO_W    = 8;
    localparam int BIT_W    = 4;
    localparam int UNITS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST_A = 5'd1,
        PH_ST_B = 5'd2,
        PH_SP_A = 5'd3,
        PH_SP_B = 5'd4,
        PH_WA_A = 5'd5,
        PH_WA_B = 5'd6,
        PH_WA_P = 5'd7,
        PH_WB_D = 5'd8,
        PH_WB_H = 5'd9,
        PH_WB_L = 5'd10,
        PH_RB_L = 5'd11,
        PH_RB_H = 5'd12,
        PH_AK_A = 5'd13,
        PH_AK_B = 5'd14
    } phase_t;

    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WAIT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT    = 2'd1;

    localparam logic [TPU_W-1:0] TPU_RESET = 16'd10;
    localparam logic [TMO_W-1:0] TMO_RESET = 8'd250;

    // Remaining extra units after the first, for 4, 2 and 1 unit phases.
    localparam logic [UNITS_W-1:0] UNITS_FOUR = 2'd3;
    localparam logic [UNITS_W-1:0] UNITS_TWO  = 2'd1;
    localparam logic [UNITS_W-1:0] UNITS_ONE  = 2'd0;

    localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

endpackage

>>> hdl/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: tick-driven phase machine
// with a registered result stage. Depends on i2cbs_pkg.
//
//  Channel   Direction  Signals                        Carries
//  s_*       in         s_tvalid s_tready s_tdata s_tuser  one tick (+command)
//  m_*       out        m_tvalid m_tready m_tdata      bus levels and status
//  cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// Every transfer on the input channel is one bus tick and produces exactly one
// result transfer. A tick is taken in every cycle that the input does not stall; the result
// appears in the next cycle in the output register, which the phase logic feeds in a single pass.
// The input stalls only while a result waits and m_tready is low.
// Reset (rst_n low, asynchronous) returns the machine to idle with both lines
// released high; the registers return to 10 ticks per unit and a timeout of 250.
module i2c_master_bit_sequencer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tx_byte [7:0], ack_after_read [8], sda_sample [9], zero fill [15:10]
    input  logic [i2cbs_pkg::S_DATA_W-1:0]       s_tdata,
    // kind [2:0]
    input  logic [i2cbs_pkg::KIND_W-1:0]         s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // scl_level [0], sda_level [1], sda_drive [2], busy_res [3], done_res [4],
    // rx_byte [12:5], ack_missing [13], zero fill [15:14]
    output logic [i2cbs_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [i2cbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [i2cbs_pkg::CFG_DAT_W-1:0]      cfg_data
);

    // Configuration registers.
    logic [i2cbs_pkg::TPU_W-1:0]   tpu_reg;
    logic [i2cbs_pkg::TMO_W-1:0]   timeout_reg;

    // Sequencer state.
    i2cbs_pkg::phase_t             phase_reg, phase_next;
    logic [i2cbs_pkg::BIT_W-1:0]   bit_reg, bit_next;
    logic [i2cbs_pkg::TPU_W-1:0]   delay_reg, delay_next;
    logic [i2cbs_pkg::UNITS_W-1:0] units_reg, units_next;
    logic [i2cbs_pkg::BYTE_W-1:0]  shift_reg, shift_next;
    logic [i2cbs_pkg::TMO_W-1:0]   poll_reg, poll_next;
    logic                          ack_choice_reg, ack_choice_next;
    logic                          scl_reg, scl_next;
    logic                          sda_reg, sda_next;
    logic                          drive_reg, drive_next;
    logic                          failed_reg, failed_next;
    logic [i2cbs_pkg::BYTE_W-1:0]  rx_reg, rx_next;
    logic                          done_next;

    // Result stage.
    logic                          m_tvalid_reg;
    logic [i2cbs_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [i2cbs_pkg::KIND_W-1:0]  in_kind;
    logic [i2cbs_pkg::BYTE_W-1:0]  in_tx;
    logic                          in_ack;
    logic                          in_sda;
    logic [i2cbs_pkg::TPU_W-1:0]   unit_ticks;
    logic                          s_accept;
    logic                          enter_req;
    i2cbs_pkg::phase_t             enter_ph;

    assign in_tx    = s_tdata[7:0];
    assign in_ack   = s_tdata[8];
    assign in_sda   = s_tdata[9];
    assign in_kind  = s_tuser;

    // A zero unit length behaves as one tick.
    assign unit_ticks = (tpu_reg == '0) ? {{(i2cbs_pkg::TPU_W-1){1'b0}}, 1'b1} : tpu_reg;

    // The output register frees up in the same cycle its result is taken.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg     <= i2cbs_pkg::TPU_RESET;
            timeout_reg <= i2cbs_pkg::TMO_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                i2cbs_pkg::CFG_TICKS_PER_UNIT: tpu_reg <= cfg_data;
                i2cbs_pkg::CFG_ACK_TIMEOUT:    timeout_reg <= cfg_data[i2cbs_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // Next-state logic. The first part decides whether the tick counts down,
    // starts a command or ends the current phase; the second part applies the
    // entry actions of the phase being entered.
    always_comb
    begin
        phase_next      = phase_reg;
        bit_next        = bit_reg;
        delay_next      = delay_reg;
        units_next      = units_reg;
        shift_next      = shift_reg;
        poll_next       = poll_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        drive_next      = drive_reg;
        failed_next     = failed_reg;
        rx_next         = rx_reg;
        done_next       = 1'b0;
        enter_req       = 1'b0;
        enter_ph        = i2cbs_pkg::PH_IDLE;

        if (phase_reg == i2cbs_pkg::PH_IDLE)
        begin
            case (in_kind)
                i2cbs_pkg::KIND_START:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_ST_A;
                end
                i2cbs_pkg::KIND_STOP:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_SP_A;
                end
                i2cbs_pkg::KIND_WRITE:
                begin
                    shift_next = in_tx;
                    bit_next   = '0;
                    enter_req  = 1'b1;
                    enter_ph   = i2cbs_pkg::PH_WB_D;
                end
                i2cbs_pkg::KIND_WAIT:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_WA_A;
                end
                i2cbs_pkg::KIND_READ:
                begin
                    ack_choice_next = in_ack;
                    bit_next        = '0;
                    shift_next      = '0;
                    enter_req       = 1'b1;
                    enter_ph        = i2cbs_pkg::PH_RB_L;
                end
                default: ;
            endcase
        end
        else if (phase_reg == i2cbs_pkg::PH_WA_P)
        begin
            // Acknowledge polling re-evaluates on every tick.
            enter_req = 1'b1;
            enter_ph  = i2cbs_pkg::PH_WA_P;
        end
        else if (delay_reg > {{(i2cbs_pkg::TPU_W-1){1'b0}}, 1'b1})
        begin
            delay_next = delay_reg - 1'b1;
        end
        else if (units_reg != '0)
        begin
            units_next = units_reg - 1'b1;
            delay_next = unit_ticks;
        end
        else
        begin
            case (phase_reg)
                i2cbs_pkg::PH_ST_A:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_ST_B;
                end
                i2cbs_pkg::PH_ST_B:
                begin
                    scl_next   = 1'b0;
                    phase_next = i2cbs_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                i2cbs_pkg::PH_SP_A:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_SP_B;
                end
                i2cbs_pkg::PH_SP_B:
                begin
                    phase_next = i2cbs_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                i2cbs_pkg::PH_WA_A:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_WA_B;
                end
                i2cbs_pkg::PH_WA_B:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_WA_P;
                end
                i2cbs_pkg::PH_WB_D:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_WB_H;
                end
                i2cbs_pkg::PH_WB_H:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_WB_L;
                end
                i2cbs_pkg::PH_WB_L:
                begin
                    bit_next = bit_reg + 1'b1;
                    if (bit_next < i2cbs_pkg::BITS_PER_BYTE)
                    begin
                        enter_req = 1'b1;
                        enter_ph  = i2cbs_pkg::PH_WB_D;
                    end
                    else
                    begin
                        phase_next = i2cbs_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                i2cbs_pkg::PH_RB_L:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_RB_H;
                end
                i2cbs_pkg::PH_RB_H:
                begin
                    bit_next  = bit_reg + 1'b1;
                    enter_req = 1'b1;
                    enter_ph  = (bit_next < i2cbs_pkg::BITS_PER_BYTE) ?
                                i2cbs_pkg::PH_RB_L : i2cbs_pkg::PH_AK_A;
                end
                i2cbs_pkg::PH_AK_A:
                begin
                    enter_req = 1'b1;
                    enter_ph  = i2cbs_pkg::PH_AK_B;
                end
                i2cbs_pkg::PH_AK_B:
                begin
                    scl_next   = 1'b0;
                    rx_next    = shift_reg;
                    phase_next = i2cbs_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                default: phase_next = i2cbs_pkg::PH_IDLE;
            endcase
        end

        if (enter_req)
        begin
            phase_next = enter_ph;
            case (enter_ph)
                i2cbs_pkg::PH_ST_A:
                begin
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_FOUR;
                end
                i2cbs_pkg::PH_ST_B:
                begin
                    sda_next   = 1'b0;
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_FOUR;
                end
                i2cbs_pkg::PH_SP_A:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_FOUR;
                end
                i2cbs_pkg::PH_SP_B:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_FOUR;
                end
                i2cbs_pkg::PH_WA_A:
                begin
                    drive_next  = 1'b0;
                    sda_next    = 1'b1;
                    poll_next   = '0;
                    failed_next = 1'b0;
                    delay_next  = unit_ticks;
                    units_next  = i2cbs_pkg::UNITS_ONE;
                end
                i2cbs_pkg::PH_WA_B:
                begin
                    scl_next   = 1'b1;
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_ONE;
                end
                i2cbs_pkg::PH_WA_P:
                begin
                    if (!in_sda)
                    begin
                        // Acknowledge seen: drop SCL and finish.
                        scl_next   = 1'b0;
                        phase_next = i2cbs_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else if (poll_reg >= timeout_reg)
                    begin
                        // Timed out: flag it and run the stop sequence.
                        failed_next = 1'b1;
                        phase_next  = i2cbs_pkg::PH_SP_A;
                        drive_next  = 1'b1;
                        scl_next    = 1'b0;
                        sda_next    = 1'b0;
                        delay_next  = unit_ticks;
                        units_next  = i2cbs_pkg::UNITS_FOUR;
                    end
                    else
                    begin
                        poll_next = poll_reg + 1'b1;
                    end
                end
                i2cbs_pkg::PH_WB_D:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = shift_next[i2cbs_pkg::BYTE_W-1];
                    shift_next = {shift_next[i2cbs_pkg::BYTE_W-2:0], 1'b0};
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_TWO;
                end
                i2cbs_pkg::PH_WB_H, i2cbs_pkg::PH_AK_B:
                begin
                    scl_next   = 1'b1;
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_TWO;
                end
                i2cbs_pkg::PH_WB_L:
                begin
                    scl_next   = 1'b0;
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_TWO;
                end
                i2cbs_pkg::PH_RB_L:
                begin
                    drive_next = 1'b0;
                    scl_next   = 1'b0;
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_TWO;
                end
                i2cbs_pkg::PH_RB_H:
                begin
                    // The data bit is taken on the tick SCL rises.
                    scl_next   = 1'b1;
                    shift_next = {shift_next[i2cbs_pkg::BYTE_W-2:0], in_sda};
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_ONE;
                end
                i2cbs_pkg::PH_AK_A:
                begin
                    scl_next   = 1'b0;
                    drive_next = 1'b1;
                    sda_next   = !ack_choice_next;
                    delay_next = unit_ticks;
                    units_next = i2cbs_pkg::UNITS_TWO;
                end
                default: phase_next = i2cbs_pkg::PH_IDLE;
            endcase
        end

        // A released SDA reads as high through its pull-up.
        m_tdata_next = {2'b00,
                        failed_next,
                        rx_next,
                        done_next,
                        (phase_next != i2cbs_pkg::PH_IDLE),
                        drive_next,
                        (drive_next ? sda_next : 1'b1),
                        scl_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2cbs_pkg::PH_IDLE;
            bit_reg        <= '0;
            delay_reg      <= '0;
            units_reg      <= '0;
            shift_reg      <= '0;
            poll_reg       <= '0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            drive_reg      <= 1'b0;
            failed_reg     <= 1'b0;
            rx_reg         <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                phase_reg      <= phase_next;
                bit_reg        <= bit_next;
                delay_reg      <= delay_next;
                units_reg      <= units_next;
                shift_reg      <= shift_next;
                poll_reg       <= poll_next;
                ack_choice_reg <= ack_choice_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                drive_reg      <= drive_next;
                failed_reg     <= failed_next;
                rx_reg         <= rx_next;
                m_tvalid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

>>> verif/i2c_master_bit_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master bit sequencer: one tick per stream transfer,
// a built-in model of the phase machine, checks on every result. Needs i2cbs_pkg and the RTL.
module i2c_master_bit_sequencer_test;

    typedef logic [i2cbs_pkg::KIND_W-1:0]    kind_t;
    typedef logic [i2cbs_pkg::BYTE_W-1:0]    byte_t;
    typedef logic [i2cbs_pkg::TPU_W-1:0]     tpu_t;
    typedef logic [i2cbs_pkg::TMO_W-1:0]     tmo_t;
    typedef logic [i2cbs_pkg::BIT_W-1:0]     bit_cnt_t;
    typedef logic [i2cbs_pkg::UNITS_W-1:0]   units_t;
    typedef logic [i2cbs_pkg::CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [i2cbs_pkg::CFG_DAT_W-1:0] cfg_dat_t;

    // Kind codes that the block treats as a plain tick.
    localparam kind_t KIND_SPARE6 = 3'd6;
    localparam kind_t KIND_SPARE7 = 3'd7;
    // A register index with no register behind it; writes to it are dropped.
    localparam cfg_idx_t CFG_SPARE = 2'd2;

    localparam int RANDOM_TICKS = 300;

    // One tick as the sender sees it.
    typedef struct packed {
        kind_t             kind;
        byte_t             tx;
        logic              ack;
        logic              sda;
    } tick_item_t;

    // Bus levels and status after one tick.
    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              drive;
        logic              busy;
        logic              done;
        byte_t             rx;
        logic              ack_missing;
    } bus_lines_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [i2cbs_pkg::S_DATA_W-1:0] s_tdata = '0;
    kind_t s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [i2cbs_pkg::M_DATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_idx_t cfg_index = '0;
    cfg_dat_t cfg_data = '0;

    i2c_master_bit_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Ticks waiting to be sent, and bus levels waiting to be seen.
    tick_item_t tick_queue[$];
    bus_lines_t expected_lines[$];

    int errors = 0;
    int ticks_taken = 0;
    int results_seen = 0;
    int ack_timeouts = 0;
    int starts_by_kind[8];
    bit tick_taken = 1'b0;

    // ------------------------------------------------------------------
    // Bus model. It mirrors the sequencer state and is stepped once per
    // accepted tick, in the same order the block sees the ticks.
    // ------------------------------------------------------------------
    tpu_t                tpu_q = i2cbs_pkg::TPU_RESET;
    tmo_t                tmo_q = i2cbs_pkg::TMO_RESET;
    i2cbs_pkg::phase_t   cur_phase = i2cbs_pkg::PH_IDLE;
    bit_cnt_t            bit_cnt = '0;
    tpu_t                dly_cnt = '0;
    units_t              extra_units = '0;
    byte_t               shift_q = '0;
    tmo_t                poll_cnt = '0;
    logic                ack_sel = 1'b0;
    logic                scl_q = 1'b1;
    logic                sda_q = 1'b1;
    logic                drive_q = 1'b0;
    logic                nack_q = 1'b0;
    logic                done_q = 1'b0;
    byte_t               rx_q = '0;

    // A zero unit length behaves as a single tick.
    task automatic hold_units(input units_t extra);
        dly_cnt = (tpu_q == '0) ? tpu_t'(1) : tpu_q;
        extra_units = extra;
    endtask

    task automatic wrap_up();
        cur_phase = i2cbs_pkg::PH_IDLE;
        done_q = 1'b1;
    endtask

    // Line changes of a phase happen on its first tick. Polling for an
    // acknowledge re-enters the poll phase on every tick; a high sample
    // at or past the timeout turns it into the first half of a stop.
    task automatic enter_phase(input i2cbs_pkg::phase_t p, input logic sda);
        i2cbs_pkg::phase_t nxt;
        nxt = p;
        if (p == i2cbs_pkg::PH_WA_P && sda && poll_cnt >= tmo_q)
        begin
            nack_q = 1'b1;
            ack_timeouts++;
            nxt = i2cbs_pkg::PH_SP_A;
        end
        cur_phase = nxt;
        case (nxt)
            i2cbs_pkg::PH_ST_A:
            begin
                drive_q = 1'b1;
                sda_q = 1'b1;
                scl_q = 1'b1;
                hold_units(i2cbs_pkg::UNITS_FOUR);
            end
            i2cbs_pkg::PH_ST_B:
            begin
                sda_q = 1'b0;
                hold_units(i2cbs_pkg::UNITS_FOUR);
            end
            i2cbs_pkg::PH_SP_A:
            begin
                drive_q = 1'b1;
                scl_q = 1'b0;
                sda_q = 1'b0;
                hold_units(i2cbs_pkg::UNITS_FOUR);
            end
            i2cbs_pkg::PH_SP_B:
            begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                hold_units(i2cbs_pkg::UNITS_FOUR);
            end
            i2cbs_pkg::PH_WA_A:
            begin
                drive_q = 1'b0;
                sda_q = 1'b1;
                poll_cnt = '0;
                nack_q = 1'b0;
                hold_units(i2cbs_pkg::UNITS_ONE);
            end
            i2cbs_pkg::PH_WA_B:
            begin
                scl_q = 1'b1;
                hold_units(i2cbs_pkg::UNITS_ONE);
            end
            i2cbs_pkg::PH_WA_P:
            begin
                if (!sda)
                begin
                    scl_q = 1'b0;
                    wrap_up();
                end
                else
                begin
                    poll_cnt = poll_cnt + 1'b1;
                end
            end
            i2cbs_pkg::PH_WB_D:
            begin
                drive_q = 1'b1;
                scl_q = 1'b0;
                sda_q = shift_q[i2cbs_pkg::BYTE_W-1];
                shift_q = shift_q << 1;
                hold_units(i2cbs_pkg::UNITS_TWO);
            end
            i2cbs_pkg::PH_WB_H:
            begin
                scl_q = 1'b1;
                hold_units(i2cbs_pkg::UNITS_TWO);
            end
            i2cbs_pkg::PH_WB_L:
            begin
                scl_q = 1'b0;
                hold_units(i2cbs_pkg::UNITS_TWO);
            end
            i2cbs_pkg::PH_RB_L:
            begin
                drive_q = 1'b0;
                scl_q = 1'b0;
                hold_units(i2cbs_pkg::UNITS_TWO);
            end
            i2cbs_pkg::PH_RB_H:
            begin
                scl_q = 1'b1;
                shift_q = {shift_q[i2cbs_pkg::BYTE_W-2:0], sda};
                hold_units(i2cbs_pkg::UNITS_ONE);
            end
            i2cbs_pkg::PH_AK_A:
            begin
                scl_q = 1'b0;
                drive_q = 1'b1;
                sda_q = !ack_sel;
                hold_units(i2cbs_pkg::UNITS_TWO);
            end
            i2cbs_pkg::PH_AK_B:
            begin
                scl_q = 1'b1;
                hold_units(i2cbs_pkg::UNITS_TWO);
            end
            default: cur_phase = i2cbs_pkg::PH_IDLE;
        endcase
    endtask

    // Called when the last tick of a phase has passed.
    task automatic next_phase(input logic sda);
        case (cur_phase)
            i2cbs_pkg::PH_ST_A: enter_phase(i2cbs_pkg::PH_ST_B, sda);
            i2cbs_pkg::PH_ST_B:
            begin
                scl_q = 1'b0;
                wrap_up();
            end
            i2cbs_pkg::PH_SP_A: enter_phase(i2cbs_pkg::PH_SP_B, sda);
            i2cbs_pkg::PH_SP_B: wrap_up();
            i2cbs_pkg::PH_WA_A: enter_phase(i2cbs_pkg::PH_WA_B, sda);
            i2cbs_pkg::PH_WA_B: enter_phase(i2cbs_pkg::PH_WA_P, sda);
            i2cbs_pkg::PH_WB_D: enter_phase(i2cbs_pkg::PH_WB_H, sda);
            i2cbs_pkg::PH_WB_H: enter_phase(i2cbs_pkg::PH_WB_L, sda);
            i2cbs_pkg::PH_WB_L:
            begin
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt < i2cbs_pkg::BITS_PER_BYTE)
                    enter_phase(i2cbs_pkg::PH_WB_D, sda);
                else
                    wrap_up();
            end
            i2cbs_pkg::PH_RB_L: enter_phase(i2cbs_pkg::PH_RB_H, sda);
            i2cbs_pkg::PH_RB_H:
            begin
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt < i2cbs_pkg::BITS_PER_BYTE)
                    enter_phase(i2cbs_pkg::PH_RB_L, sda);
                else
                    enter_phase(i2cbs_pkg::PH_AK_A, sda);
            end
            i2cbs_pkg::PH_AK_A: enter_phase(i2cbs_pkg::PH_AK_B, sda);
            i2cbs_pkg::PH_AK_B:
            begin
                scl_q = 1'b0;
                rx_q = shift_q;
                wrap_up();
            end
            default: cur_phase = i2cbs_pkg::PH_IDLE;
        endcase
    endtask

    // One bus tick: commands count only while idle, everything else just
    // runs the timers of the current phase.
    task automatic bus_tick(input tick_item_t it, output bus_lines_t lines);
        done_q = 1'b0;
        if (cur_phase == i2cbs_pkg::PH_IDLE)
        begin
            if (it.kind >= i2cbs_pkg::KIND_START && it.kind <= i2cbs_pkg::KIND_READ)
                starts_by_kind[it.kind]++;
            case (it.kind)
                i2cbs_pkg::KIND_START: enter_phase(i2cbs_pkg::PH_ST_A, it.sda);
                i2cbs_pkg::KIND_STOP:  enter_phase(i2cbs_pkg::PH_SP_A, it.sda);
                i2cbs_pkg::KIND_WRITE:
                begin
                    shift_q = it.tx;
                    bit_cnt = '0;
                    enter_phase(i2cbs_pkg::PH_WB_D, it.sda);
                end
                i2cbs_pkg::KIND_WAIT:  enter_phase(i2cbs_pkg::PH_WA_A, it.sda);
                i2cbs_pkg::KIND_READ:
                begin
                    ack_sel = it.ack;
                    bit_cnt = '0;
                    shift_q = '0;
                    enter_phase(i2cbs_pkg::PH_RB_L, it.sda);
                end
                default: ;
            endcase
        end
        else if (cur_phase == i2cbs_pkg::PH_WA_P)
        begin
            enter_phase(i2cbs_pkg::PH_WA_P, it.sda);
        end
        else if (dly_cnt > tpu_t'(1))
        begin
            dly_cnt = dly_cnt - 1'b1;
        end
        else if (extra_units != '0)
        begin
            extra_units = extra_units - 1'b1;
            hold_units(extra_units);
        end
        else
        begin
            next_phase(it.sda);
        end
        lines.scl = scl_q;
        lines.sda = drive_q ? sda_q : 1'b1;   // a released line floats high
        lines.drive = drive_q;
        lines.busy = (cur_phase != i2cbs_pkg::PH_IDLE);
        lines.done = done_q;
        lines.rx = rx_q;
        lines.ack_missing = nack_q;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sampling at the rising edge. The result of a tick shows up in the
    // cycle after its transfer, so the oldest expectation is consumed
    // before the newest one is added.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bus_lines_t want;
        bus_lines_t fresh;
        tick_item_t it;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_lines.size() == 0)
                begin
                    $error("result transfer with no tick outstanding: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    check_field("scl_level", want.scl, m_tdata[0]);
                    check_field("sda_level", want.sda, m_tdata[1]);
                    check_field("sda_drive", want.drive, m_tdata[2]);
                    check_field("busy_res", want.busy, m_tdata[3]);
                    check_field("done_res", want.done, m_tdata[4]);
                    check_field("rx_byte", want.rx, m_tdata[12:5]);
                    check_field("ack_missing", want.ack_missing, m_tdata[13]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                it.kind = s_tuser;
                it.tx = s_tdata[7:0];
                it.ack = s_tdata[8];
                it.sda = s_tdata[9];
                bus_tick(it, fresh);
                expected_lines.push_back(fresh);
                ticks_taken++;
                tick_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps. A tick once
    // offered stays on the bus until it is taken.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        tick_item_t it;
        bit was_taken;
        was_taken = tick_taken;
        if (tick_taken)
        begin
            tick_taken = 1'b0;
            void'(tick_queue.pop_front());
        end
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!(s_tvalid && !was_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (tick_queue.size() != 0)
            begin
                it = tick_queue[0];
                s_tuser <= it.kind;
                s_tdata <= {6'b0, it.sda, it.ack, it.tx};
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    // Many bursts run back to back, which gives long
                    // stretches with a tick in every cycle.
                    burst_left = $urandom_range(1, 60);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: its readiness follows modes picked at random, from
    // always ready to mostly stalled.
    // ------------------------------------------------------------------
    int ready_mode = 0;
    int ready_run = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (ready_run == 0)
            begin
                ready_run = 150;
                ready_mode = $urandom_range(0, 3);
            end
            ready_run--;
            case (ready_mode)
                2: m_tready <= ($urandom_range(0, 3) != 0);
                3: m_tready <= ($urandom_range(0, 2) == 0);
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // sda_odds: 0 keeps SDA high, n pulls it low on one tick in n.
    // With noise, some ticks carry a command that a busy block must ignore.
    function automatic tick_item_t make_tick(input int sda_odds, input bit noise);
        tick_item_t it;
        it.kind = i2cbs_pkg::KIND_TICK;
        if (noise && $urandom_range(0, 15) == 0)
            it.kind = kind_t'($urandom_range(i2cbs_pkg::KIND_START, KIND_SPARE7));
        else if ($urandom_range(0, 9) == 0)
            it.kind = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
        it.tx = byte_t'($urandom_range(0, 255));
        it.ack = 1'($urandom_range(0, 1));
        it.sda = (sda_odds == 0) ? 1'b1 : ($urandom_range(1, sda_odds) != 1);
        return it;
    endfunction

    // Keep feeding ticks until the model says the sequencer is idle.
    task automatic run_to_idle(input int sda_odds, input int batch, input bit noise);
        bit running;
        running = 1'b1;
        while (running)
        begin
            while (tick_queue.size() != 0)
                @(posedge clk);
            if (cur_phase == i2cbs_pkg::PH_IDLE)
                running = 1'b0;
            else
                repeat (batch) tick_queue.push_back(make_tick(sda_odds, noise));
        end
    endtask

    task automatic issue(input kind_t kind, input byte_t tx,
                         input logic ack, input int sda_odds, input int batch,
                         input bit noise);
        tick_item_t it;
        it = make_tick(sda_odds, 1'b0);
        it.kind = kind;
        it.tx = tx;
        it.ack = ack;
        tick_queue.push_back(it);
        run_to_idle(sda_odds, batch, noise);
    endtask

    // Register writes happen only with nothing in flight.
    task automatic write_reg(input cfg_idx_t idx, input cfg_dat_t data);
        while (tick_queue.size() != 0 || expected_lines.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            i2cbs_pkg::CFG_TICKS_PER_UNIT: tpu_q = data;
            i2cbs_pkg::CFG_ACK_TIMEOUT:    tmo_q = data[i2cbs_pkg::TMO_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The upper byte of the timeout word is junk that must be dropped.
    task automatic set_timing(input tpu_t tpu, input tmo_t tmo);
        write_reg(i2cbs_pkg::CFG_TICKS_PER_UNIT, tpu);
        write_reg(i2cbs_pkg::CFG_ACK_TIMEOUT, {8'($urandom_range(0, 255)), tmo});
    endtask

    function automatic int pick_ack_odds();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 2;
            2: return 4;
            3: return 64;
            default: return 16;
        endcase
    endfunction

    // Mostly a proper transaction: start, address byte, acknowledge, a few
    // data bytes in either direction, stop. Now and then a lone command.
    task automatic random_transaction();
        int n;
        if ($urandom_range(0, 5) == 0)
        begin
            issue(kind_t'($urandom_range(0, 7)), byte_t'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), pick_ack_odds(), 16, 1'b1);
        end
        else
        begin
            issue(i2cbs_pkg::KIND_START, 8'h00, 1'b0, 2, 16, 1'b1);
            issue(i2cbs_pkg::KIND_WRITE, byte_t'($urandom_range(0, 255)), 1'b0, 2, 16, 1'b1);
            issue(i2cbs_pkg::KIND_WAIT, 8'h00, 1'b0, pick_ack_odds(), 16, 1'b1);
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                if ($urandom_range(0, 1))
                begin
                    issue(i2cbs_pkg::KIND_WRITE, byte_t'($urandom_range(0, 255)), 1'b0,
                          2, 16, 1'b1);
                    issue(i2cbs_pkg::KIND_WAIT, 8'h00, 1'b0, pick_ack_odds(), 16, 1'b1);
                end
                else
                begin
                    issue(i2cbs_pkg::KIND_READ, 8'h00, 1'($urandom_range(0, 1)), 2, 16, 1'b1);
                end
            end
            issue(i2cbs_pkg::KIND_STOP, 8'h00, 1'b0, 2, 16, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int target;
        int drain;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset timing (10 ticks per unit, timeout 250), before any write.
        issue(i2cbs_pkg::KIND_TICK, 8'h00, 1'b0, 2, 16, 1'b1);
        issue(KIND_SPARE6, 8'hFF, 1'b1, 2, 16, 1'b1);
        issue(KIND_SPARE7, 8'h00, 1'b0, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_START, 8'h00, 1'b0, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_WRITE, 8'hFF, 1'b0, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_WAIT, 8'h00, 1'b0, 16, 16, 1'b1);
        issue(i2cbs_pkg::KIND_READ, 8'h00, 1'b1, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_STOP, 8'h00, 1'b0, 2, 16, 1'b1);

        // Shortest unit and a zero timeout: one high poll already fails.
        set_timing(tpu_t'(1), tmo_t'(0));
        issue(i2cbs_pkg::KIND_WAIT, 8'h00, 1'b0, 0, 16, 1'b1);
        issue(i2cbs_pkg::KIND_WRITE, 8'h00, 1'b0, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_WRITE, 8'hA5, 1'b0, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_READ, 8'h00, 1'b0, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_WAIT, 8'h00, 1'b0, 2, 16, 1'b1);

        // Longest timeout: SDA held high runs the whole poll, then a stop.
        set_timing(tpu_t'(1), tmo_t'(255));
        issue(i2cbs_pkg::KIND_WAIT, 8'h00, 1'b0, 0, 16, 1'b1);
        issue(i2cbs_pkg::KIND_WAIT, 8'h00, 1'b0, 64, 16, 1'b1);

        // A zero unit length acts as one tick.
        set_timing(tpu_t'(0), tmo_t'(1));
        issue(i2cbs_pkg::KIND_START, 8'h00, 1'b0, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_WRITE, 8'h5A, 1'b0, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_READ, 8'h00, 1'b1, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_STOP, 8'h00, 1'b0, 2, 16, 1'b1);
        issue(i2cbs_pkg::KIND_WAIT, 8'h00, 1'b0, 0, 16, 1'b1);

        // Widest unit and a write to an unused index, followed only by
        // idle ticks so the sequencer never starts a phase at this length.
        write_reg(CFG_SPARE, cfg_dat_t'($urandom_range(0, 65535)));
        set_timing(tpu_t'(65535), tmo_t'(255));
        issue(i2cbs_pkg::KIND_TICK, 8'h00, 1'b0, 2, 16, 1'b0);

        // Random part: mostly fast timing so transactions get through.
        target = ticks_taken + RANDOM_TICKS;
        while (ticks_taken < target)
        begin
            case ($urandom_range(0, 7))
                0: set_timing(tpu_t'(0), tmo_t'($urandom_range(0, 255)));
                1: set_timing(tpu_t'($urandom_range(2, 6)), tmo_t'(255));
                2: set_timing(tpu_t'(2), tmo_t'($urandom_range(0, 20)));
                default: set_timing(tpu_t'(1), $urandom_range(0, 1) ?
                                    tmo_t'($urandom_range(0, 255)) :
                                    tmo_t'($urandom_range(0, 8)));
            endcase
            repeat ($urandom_range(2, 4)) random_transaction();
        end

        // Let the last results come out, then allow a few quiet cycles in
        // which nothing unexpected may appear.
        drain = 0;
        while ((tick_queue.size() != 0 || expected_lines.size() != 0) && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (expected_lines.size() != 0)
        begin
            $error("%0d results never arrived", expected_lines.size());
            errors++;
        end

        $display("Ran %0d ticks and checked %0d results; %0d acknowledge timeouts.",
                 ticks_taken, results_seen, ack_timeouts);
        $display("Commands begun: start %0d, stop %0d, write %0d, wait %0d, read %0d.",
                 starts_by_kind[i2cbs_pkg::KIND_START], starts_by_kind[i2cbs_pkg::KIND_STOP],
                 starts_by_kind[i2cbs_pkg::KIND_WRITE], starts_by_kind[i2cbs_pkg::KIND_WAIT],
                 starts_by_kind[i2cbs_pkg::KIND_READ]);
        if (errors == 0)
            $display("i2c_master_bit_sequencer_test: clean");
        else
            $display("i2c_master_bit_sequencer_test: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, including the longest
    // acknowledge polls under the heaviest stalls.
    initial
    begin
        #(60_000_000);
        $display("i2c_master_bit_sequencer_test: errors");
        $finish;
    end

endmodule
